// ===== hw/rtl/hkpm_pkg.sv =====
// Package with the shared widths, codes, types and defaults of the k-means move engine.
package hkpm_pkg;

    localparam int unsigned MAX_CLUSTERS_DEF = 256;
    localparam int unsigned MAX_DIMS_DEF     = 128;
    localparam int unsigned COUNT_BITS_DEF   = 25;

    localparam int unsigned LABEL_W    = 8;
    localparam int unsigned LABEL_NUM  = 256;
    localparam int unsigned SAMPLE_W   = 16;
    localparam int unsigned STATUS_W   = 2;
    localparam int unsigned SUM_W      = 48;
    localparam int unsigned MAG_W      = 48;
    localparam int unsigned HALF_W     = 24;
    localparam int unsigned NUM_W      = 128;
    localparam int unsigned FRAC_W     = 16;
    localparam int unsigned DIVC_W     = 7;

    localparam int unsigned NCLU_REG_W = 9;
    localparam int unsigned NDIM_REG_W = 8;
    localparam int unsigned THR_W      = 32;
    localparam int unsigned APB_DATA_W = 32;
    localparam int unsigned APB_ADDR_W = 4;

    localparam logic [NCLU_REG_W-1:0] NUM_CLUSTERS_RST = 9'd256;
    localparam logic [NDIM_REG_W-1:0] NUM_DIMS_RST     = 8'd128;
    localparam logic [THR_W-1:0]      THRESHOLD_RST    = 32'd7;

    localparam logic [1:0] REG_NUM_CLUSTERS = 2'd0;
    localparam logic [1:0] REG_NUM_DIMS     = 2'd1;
    localparam logic [1:0] REG_THRESHOLD    = 2'd2;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_EVAL = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_MOVED   = 2'd0,
        ST_NO_GAIN = 2'd1,
        ST_SINGLE  = 2'd2
    } t_move_status;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_LD_RD,
        S_LD_WR,
        S_CNT_RD,
        S_CNT_WR,
        S_EV_RD,
        S_EV_OWN,
        S_C_RD,
        S_C_MUL,
        S_C_DIFF,
        S_C_SQ,
        S_C_DEN,
        S_C_DIV,
        S_C_DONE,
        S_CAND_RD,
        S_CAND_CHK,
        S_DECIDE,
        S_MV_RD,
        S_MV_SUB,
        S_MV_RD2,
        S_MV_ADD,
        S_MV_CRD,
        S_MV_CDEC,
        S_MV_CINC,
        S_RESULT
    } t_state;

endpackage

// ===== hw/rtl/hkpm_if.sv =====
// Request and result channel interfaces of the k-means move engine.
interface hkpm_req_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  cmd;
    logic [hkpm_pkg::LABEL_W-1:0]          current_label;
    logic signed [hkpm_pkg::SAMPLE_W-1:0]  sample_value;
    logic                                  last_component;

    modport source (output valid, cmd, current_label, sample_value, last_component,
                    input ready);
    modport sink (input valid, cmd, current_label, sample_value, last_component,
                  output ready);
endinterface

interface hkpm_rsp_if;
    logic                             valid;
    logic                             ready;
    logic [hkpm_pkg::LABEL_W-1:0]     new_label;
    logic [hkpm_pkg::STATUS_W-1:0]    move_status;

    modport source (output valid, new_label, move_status, input ready);
    modport sink (input valid, new_label, move_status, output ready);
endinterface

// ===== hw/rtl/hartigan_kmeans_point_move.sv =====
// Top level of the Hartigan k-means move engine with its sum, count and point memories.
// A load request adds its sample into the sums, and on its last component also updates the count.
// An evaluate request on its last component weighs its own cluster and the K non-empty
// candidates among the N clusters in use over D components, using the serial cost divider
// and the shared 24 by 24 bit multiplier; a point alone in its cluster is not weighed.
// One request is worked at a time. After reset a clearing pass zeroes the sums and
// counts, during which no request is taken; register writes are taken throughout.
module hartigan_kmeans_point_move #(
    parameter int unsigned MAX_CLUSTERS = hkpm_pkg::MAX_CLUSTERS_DEF,
    parameter int unsigned MAX_DIMS     = hkpm_pkg::MAX_DIMS_DEF,
    parameter int unsigned COUNT_BITS   = hkpm_pkg::COUNT_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    hkpm_req_if.sink                            i_req,
    hkpm_rsp_if.source                          o_rsp,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [hkpm_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [hkpm_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [hkpm_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);

    localparam int unsigned CL_W    = $clog2(MAX_CLUSTERS);
    localparam int unsigned CLC_W   = $clog2(MAX_CLUSTERS + 1);
    localparam int unsigned DIM_W   = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int unsigned DIMC_W  = $clog2(MAX_DIMS + 1);
    localparam int unsigned SA_W    = CL_W + DIM_W;
    localparam int unsigned DEN_W   = 2 * COUNT_BITS;
    localparam int unsigned NX_W    = COUNT_BITS + hkpm_pkg::SAMPLE_W + 1;
    localparam int unsigned DIFF_W  = ((NX_W > hkpm_pkg::SUM_W) ? NX_W : hkpm_pkg::SUM_W) + 1;
    localparam int unsigned SUM_W   = hkpm_pkg::SUM_W;
    localparam int unsigned NUM_W   = hkpm_pkg::NUM_W;
    localparam int unsigned HALF_W  = hkpm_pkg::HALF_W;

    hkpm_pkg::t_state r_state, n_state;

    logic [SUM_W-1:0]                   r_sum_mem [2**SA_W];
    logic [COUNT_BITS-1:0]              r_cnt_mem [2**CL_W];
    logic [hkpm_pkg::SAMPLE_W-1:0]      r_pb_mem  [2**DIM_W];
    logic [SUM_W-1:0]                   r_sum_rd;
    logic [COUNT_BITS-1:0]              r_cnt_rd;
    logic signed [hkpm_pkg::SAMPLE_W-1:0] r_pb_rd;

    logic [SA_W-1:0]                    r_clr;
    logic [DIMC_W-1:0]                  r_idx;
    logic [hkpm_pkg::NCLU_REG_W-1:0]    r_num_clusters;
    logic [hkpm_pkg::NDIM_REG_W-1:0]    r_num_dims;
    logic [hkpm_pkg::THR_W-1:0]         r_thr;
    logic                               r_out_valid;

    logic                               r_last;
    logic [CL_W-1:0]                    r_lab;
    logic signed [hkpm_pkg::SAMPLE_W-1:0] r_x;
    logic [DIM_W-1:0]                   r_widx;
    logic [CL_W-1:0]                    r_c;
    logic [CL_W-1:0]                    r_best;
    logic [CLC_W-1:0]                   r_k;
    logic [DIM_W-1:0]                   r_d;
    logic [COUNT_BITS-1:0]              r_n;
    logic                               r_join;
    logic                               r_found;
    logic signed [NX_W-1:0]             r_nx;
    logic [hkpm_pkg::MAG_W-1:0]         r_mag;
    logic [1:0]                         r_sq;
    logic [NUM_W-1:0]                   r_pp;
    logic [NUM_W-1:0]                   r_acc;
    logic [DEN_W-1:0]                   r_den;
    logic [NUM_W-1:0]                   r_num;
    logic [DEN_W:0]                     r_rem;
    logic [hkpm_pkg::DIVC_W-1:0]        r_divc;
    logic [NUM_W-1:0]                   r_a;
    logic [NUM_W-1:0]                   r_bbest;
    logic [CL_W-1:0]                    r_res_label;
    hkpm_pkg::t_move_status             r_res_status;
    logic [hkpm_pkg::LABEL_W-1:0]       r_out_label;
    hkpm_pkg::t_move_status             r_out_status;

    logic [CL_W-1:0]                    lab_tbl [hkpm_pkg::LABEL_NUM];
    logic [DIMC_W-1:0]                  dims_eff;
    logic [CLC_W-1:0]                   nclu;
    logic                               in_ready;
    logic                               in_acc;
    logic                               in_range;
    logic                               d_last;
    logic                               cand_skip;
    logic                               gain_ok;
    logic                               load_out;
    logic                               cfg_we;
    logic                               sum_we;
    logic [SA_W-1:0]                    sum_waddr;
    logic [SA_W-1:0]                    sum_raddr;
    logic [SUM_W-1:0]                   sum_wdata;
    logic                               cnt_we;
    logic [CL_W-1:0]                    cnt_waddr;
    logic [CL_W-1:0]                    cnt_raddr;
    logic [COUNT_BITS-1:0]              cnt_wdata;
    logic [COUNT_BITS-1:0]              cnt_inc;
    logic [SUM_W-1:0]                   x_ext;
    logic [SUM_W-1:0]                   pb_ext;
    logic signed [NX_W-1:0]             nx_c;
    logic signed [DIFF_W-1:0]           diff;
    logic [DIFF_W-1:0]                  mag;
    logic [HALF_W-1:0]                  mul_a;
    logic [HALF_W-1:0]                  mul_b;
    logic [2*HALF_W-1:0]                mul_p;
    logic [NUM_W-1:0]                   pp;
    logic [COUNT_BITS:0]                n_adj;
    logic [DEN_W:0]                     den_full;
    logic [DEN_W:0]                     rem_sh;
    logic                               rem_ge;
    logic [NUM_W:0]                     best_thr;

    for (genvar g = 0; g < hkpm_pkg::LABEL_NUM; g++) begin : g_lab
        localparam int unsigned LabMod = g % MAX_CLUSTERS;
        assign lab_tbl[g] = CL_W'(LabMod);
    end

    always_comb begin
        if (r_num_dims == '0) begin
            dims_eff = DIMC_W'(1);
        end else if (32'(r_num_dims) > MAX_DIMS) begin
            dims_eff = DIMC_W'(MAX_DIMS);
        end else begin
            dims_eff = DIMC_W'(r_num_dims);
        end
        if (32'(r_num_clusters) > MAX_CLUSTERS) begin
            nclu = CLC_W'(MAX_CLUSTERS);
        end else begin
            nclu = CLC_W'(r_num_clusters);
        end
    end

    assign in_acc    = i_req.valid && in_ready;
    assign in_range  = r_idx < dims_eff;
    assign d_last    = DIMC_W'(r_d) == (dims_eff - 1'b1);
    assign cand_skip = (r_k[CL_W-1:0] == r_lab) || (r_cnt_rd == '0);
    assign load_out  = (r_state == hkpm_pkg::S_RESULT) && (!r_out_valid || o_rsp.ready);
    assign best_thr  = {1'b0, r_bbest} + (NUM_W + 1)'(r_thr);
    assign gain_ok   = r_found && (best_thr < {1'b0, r_a});

    assign x_ext   = {{(SUM_W - hkpm_pkg::SAMPLE_W){r_x[hkpm_pkg::SAMPLE_W-1]}}, r_x};
    assign pb_ext  = {{(SUM_W - hkpm_pkg::SAMPLE_W){r_pb_rd[hkpm_pkg::SAMPLE_W-1]}}, r_pb_rd};
    assign cnt_inc = (r_cnt_rd == '1) ? r_cnt_rd : r_cnt_rd + 1'b1;

    assign nx_c = $signed({1'b0, r_n}) * r_pb_rd;
    assign diff = $signed(r_sum_rd) - r_nx;
    assign mag  = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);

    always_comb begin
        mul_a = (r_sq == 2'd2) ? r_mag[2*HALF_W-1:HALF_W] : r_mag[HALF_W-1:0];
        mul_b = (r_sq == 2'd0) ? r_mag[HALF_W-1:0] : r_mag[2*HALF_W-1:HALF_W];
        mul_p = mul_a * mul_b;
        unique case (r_sq)
            2'd1:    pp = NUM_W'(mul_p) << (HALF_W + 1);
            2'd2:    pp = NUM_W'(mul_p) << (2 * HALF_W);
            default: pp = NUM_W'(mul_p);
        endcase
    end

    assign n_adj    = r_join ? {1'b0, r_n} + 1'b1 : {1'b0, r_n} - 1'b1;
    assign den_full = r_n * n_adj;
    assign rem_sh   = {r_rem[DEN_W-1:0], r_num[NUM_W-1]};
    assign rem_ge   = rem_sh >= {1'b0, r_den};

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            hkpm_pkg::S_CLEAR: begin
                if (r_clr == '1) n_state = hkpm_pkg::S_IDLE;
            end
            hkpm_pkg::S_IDLE: begin
                if (i_req.valid) begin
                    if (i_req.cmd == hkpm_pkg::CMD_LOAD && in_range) begin
                        n_state = hkpm_pkg::S_LD_RD;
                    end else if (i_req.last_component) begin
                        n_state = (i_req.cmd == hkpm_pkg::CMD_EVAL) ? hkpm_pkg::S_EV_RD
                                                                     : hkpm_pkg::S_CNT_RD;
                    end
                end
            end
            hkpm_pkg::S_LD_RD:  n_state = hkpm_pkg::S_LD_WR;
            hkpm_pkg::S_LD_WR:  n_state = r_last ? hkpm_pkg::S_CNT_RD : hkpm_pkg::S_IDLE;
            hkpm_pkg::S_CNT_RD: n_state = hkpm_pkg::S_CNT_WR;
            hkpm_pkg::S_CNT_WR: n_state = hkpm_pkg::S_IDLE;
            hkpm_pkg::S_EV_RD:  n_state = hkpm_pkg::S_EV_OWN;
            hkpm_pkg::S_EV_OWN: begin
                n_state = (r_cnt_rd <= COUNT_BITS'(1)) ? hkpm_pkg::S_RESULT : hkpm_pkg::S_C_RD;
            end
            hkpm_pkg::S_C_RD:   n_state = hkpm_pkg::S_C_MUL;
            hkpm_pkg::S_C_MUL:  n_state = hkpm_pkg::S_C_DIFF;
            hkpm_pkg::S_C_DIFF: n_state = hkpm_pkg::S_C_SQ;
            hkpm_pkg::S_C_SQ: begin
                if (r_sq == 2'd3) n_state = d_last ? hkpm_pkg::S_C_DEN : hkpm_pkg::S_C_RD;
            end
            hkpm_pkg::S_C_DEN:  n_state = hkpm_pkg::S_C_DIV;
            hkpm_pkg::S_C_DIV: begin
                if (r_divc == '1) n_state = hkpm_pkg::S_C_DONE;
            end
            hkpm_pkg::S_C_DONE: n_state = hkpm_pkg::S_CAND_RD;
            hkpm_pkg::S_CAND_RD: begin
                n_state = (r_k >= nclu) ? hkpm_pkg::S_DECIDE : hkpm_pkg::S_CAND_CHK;
            end
            hkpm_pkg::S_CAND_CHK: begin
                n_state = cand_skip ? hkpm_pkg::S_CAND_RD : hkpm_pkg::S_C_RD;
            end
            hkpm_pkg::S_DECIDE: n_state = gain_ok ? hkpm_pkg::S_MV_RD : hkpm_pkg::S_RESULT;
            hkpm_pkg::S_MV_RD:  n_state = hkpm_pkg::S_MV_SUB;
            hkpm_pkg::S_MV_SUB: n_state = hkpm_pkg::S_MV_RD2;
            hkpm_pkg::S_MV_RD2: n_state = hkpm_pkg::S_MV_ADD;
            hkpm_pkg::S_MV_ADD: n_state = d_last ? hkpm_pkg::S_MV_CRD : hkpm_pkg::S_MV_RD;
            hkpm_pkg::S_MV_CRD: n_state = hkpm_pkg::S_MV_CDEC;
            hkpm_pkg::S_MV_CDEC: n_state = hkpm_pkg::S_MV_CINC;
            hkpm_pkg::S_MV_CINC: n_state = hkpm_pkg::S_RESULT;
            hkpm_pkg::S_RESULT: begin
                if (load_out) n_state = hkpm_pkg::S_IDLE;
            end
            default: n_state = hkpm_pkg::S_IDLE;
        endcase
    end

    // Memory ports and handshake.
    always_comb begin
        in_ready  = 1'b0;
        sum_we    = 1'b0;
        sum_waddr = {r_lab, r_widx};
        sum_wdata = r_sum_rd + x_ext;
        sum_raddr = {r_c, r_d};
        cnt_we    = 1'b0;
        cnt_waddr = r_lab;
        cnt_wdata = cnt_inc;
        cnt_raddr = r_lab;
        unique case (r_state)
            hkpm_pkg::S_CLEAR: begin
                sum_we    = 1'b1;
                sum_waddr = r_clr;
                sum_wdata = '0;
                cnt_we    = 1'b1;
                cnt_waddr = r_clr[CL_W-1:0];
                cnt_wdata = '0;
            end
            hkpm_pkg::S_IDLE:    in_ready = 1'b1;
            hkpm_pkg::S_LD_RD:   sum_raddr = {r_lab, r_widx};
            hkpm_pkg::S_LD_WR:   sum_we = 1'b1;
            hkpm_pkg::S_CNT_WR:  cnt_we = 1'b1;
            hkpm_pkg::S_CAND_RD: cnt_raddr = r_k[CL_W-1:0];
            hkpm_pkg::S_MV_RD:   sum_raddr = {r_lab, r_d};
            hkpm_pkg::S_MV_SUB: begin
                sum_we    = 1'b1;
                sum_waddr = {r_lab, r_d};
                sum_wdata = r_sum_rd - pb_ext;
            end
            hkpm_pkg::S_MV_RD2:  sum_raddr = {r_best, r_d};
            hkpm_pkg::S_MV_ADD: begin
                sum_we    = 1'b1;
                sum_waddr = {r_best, r_d};
                sum_wdata = r_sum_rd + pb_ext;
            end
            hkpm_pkg::S_MV_CDEC: begin
                cnt_we    = 1'b1;
                cnt_wdata = r_cnt_rd - 1'b1;
                cnt_raddr = r_best;
            end
            hkpm_pkg::S_MV_CINC: begin
                cnt_we    = 1'b1;
                cnt_waddr = r_best;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (sum_we) r_sum_mem[sum_waddr] <= sum_wdata;
        r_sum_rd <= r_sum_mem[sum_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (cnt_we) r_cnt_mem[cnt_waddr] <= cnt_wdata;
        r_cnt_rd <= r_cnt_mem[cnt_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && i_req.cmd == hkpm_pkg::CMD_EVAL && in_range) begin
            r_pb_mem[r_idx[DIM_W-1:0]] <= i_req.sample_value;
        end
        r_pb_rd <= r_pb_mem[r_d];
    end

    assign cfg_we = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= hkpm_pkg::S_CLEAR;
            r_clr          <= '0;
            r_idx          <= '0;
            r_num_clusters <= hkpm_pkg::NUM_CLUSTERS_RST;
            r_num_dims     <= hkpm_pkg::NUM_DIMS_RST;
            r_thr          <= hkpm_pkg::THRESHOLD_RST;
            r_out_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == hkpm_pkg::S_CLEAR) r_clr <= r_clr + 1'b1;
            if (in_acc) begin
                if (i_req.last_component) begin
                    r_idx <= '0;
                end else if (in_range) begin
                    r_idx <= r_idx + 1'b1;
                end
            end
            if (cfg_we) begin
                case (paddr[3:2])
                    hkpm_pkg::REG_NUM_CLUSTERS: r_num_clusters <= pwdata[hkpm_pkg::NCLU_REG_W-1:0];
                    hkpm_pkg::REG_NUM_DIMS:     r_num_dims <= pwdata[hkpm_pkg::NDIM_REG_W-1:0];
                    hkpm_pkg::REG_THRESHOLD:    r_thr <= pwdata[hkpm_pkg::THR_W-1:0];
                    default: ;
                endcase
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            hkpm_pkg::S_IDLE: begin
                if (in_acc) begin
                    r_last <= i_req.last_component;
                    r_lab  <= lab_tbl[i_req.current_label];
                    r_x    <= i_req.sample_value;
                    r_widx <= r_idx[DIM_W-1:0];
                end
            end
            hkpm_pkg::S_EV_OWN: begin
                r_c          <= r_lab;
                r_n          <= r_cnt_rd;
                r_join       <= 1'b0;
                r_d          <= '0;
                r_acc        <= '0;
                r_sq         <= '0;
                r_found      <= 1'b0;
                r_res_label  <= r_lab;
                r_res_status <= hkpm_pkg::ST_SINGLE;
            end
            hkpm_pkg::S_C_MUL:  r_nx <= nx_c;
            hkpm_pkg::S_C_DIFF: r_mag <= mag[hkpm_pkg::MAG_W-1:0];
            hkpm_pkg::S_C_SQ: begin
                if (r_sq != 2'd3) r_pp <= pp;
                if (r_sq != 2'd0) r_acc <= r_acc + r_pp;
                r_sq <= r_sq + 1'b1;
                if (r_sq == 2'd3 && !d_last) r_d <= r_d + 1'b1;
            end
            hkpm_pkg::S_C_DEN: begin
                r_den  <= den_full[DEN_W-1:0];
                r_num  <= {r_acc[NUM_W-hkpm_pkg::FRAC_W-1:0], {hkpm_pkg::FRAC_W{1'b0}}};
                r_rem  <= '0;
                r_divc <= '0;
            end
            hkpm_pkg::S_C_DIV: begin
                r_rem  <= rem_ge ? rem_sh - {1'b0, r_den} : rem_sh;
                r_num  <= {r_num[NUM_W-2:0], rem_ge};
                r_divc <= r_divc + 1'b1;
            end
            hkpm_pkg::S_C_DONE: begin
                if (!r_join) begin
                    r_a <= r_num;
                    r_k <= '0;
                end else begin
                    if (!r_found || r_num < r_bbest) begin
                        r_bbest <= r_num;
                        r_best  <= r_c;
                        r_found <= 1'b1;
                    end
                    r_k <= r_k + 1'b1;
                end
            end
            hkpm_pkg::S_CAND_CHK: begin
                if (cand_skip) begin
                    r_k <= r_k + 1'b1;
                end else begin
                    r_c    <= r_k[CL_W-1:0];
                    r_n    <= r_cnt_rd;
                    r_join <= 1'b1;
                    r_d    <= '0;
                    r_acc  <= '0;
                    r_sq   <= '0;
                end
            end
            hkpm_pkg::S_DECIDE: begin
                r_res_label  <= r_lab;
                r_res_status <= hkpm_pkg::ST_NO_GAIN;
                r_d          <= '0;
            end
            hkpm_pkg::S_MV_ADD: begin
                if (!d_last) r_d <= r_d + 1'b1;
            end
            hkpm_pkg::S_MV_CINC: begin
                r_res_label  <= r_best;
                r_res_status <= hkpm_pkg::ST_MOVED;
            end
            hkpm_pkg::S_RESULT: begin
                if (load_out) begin
                    r_out_label  <= hkpm_pkg::LABEL_W'(r_res_label);
                    r_out_status <= r_res_status;
                end
            end
            default: ;
        endcase
    end

    assign i_req.ready       = in_ready;
    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.new_label   = r_out_label;
    assign o_rsp.move_status = r_out_status;
    assign pready            = 1'b1;

    always_comb begin
        case (paddr[3:2])
            hkpm_pkg::REG_NUM_CLUSTERS: prdata = hkpm_pkg::APB_DATA_W'(r_num_clusters);
            hkpm_pkg::REG_NUM_DIMS:     prdata = hkpm_pkg::APB_DATA_W'(r_num_dims);
            hkpm_pkg::REG_THRESHOLD:    prdata = hkpm_pkg::APB_DATA_W'(r_thr);
            default:                    prdata = '0;
        endcase
    end

endmodule
